// File: rtl/frustum_cull_test_unit_assert.svh
// Assertion macros shared by the frustum cull test unit.
`ifndef FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH
`define FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frustum cull test unit: assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FFC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frustum cull test unit: assertion failed");

`endif

// File: rtl/ffc_pkg.sv
// Shared constants, command codes and item type of the frustum cull test unit.
package ffc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int PLANE_W         = 64;
  localparam int COORD_W         = 16;
  localparam int MARGIN_W        = 15;
  localparam int AXIS_W          = 48;
  localparam int CMD_W           = 3;

  localparam logic [CMD_W-1:0] CMD_POINT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPHERE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_AABB   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OBB    = 3'd4;

  // One primitive as held for the whole evaluation, together with the box margin.
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic [MARGIN_W-1:0]       radius;
    logic [AXIS_W-1:0]         axis_u;
    logic [AXIS_W-1:0]         axis_v;
    logic [AXIS_W-1:0]         axis_w;
    logic                      last;
    logic [MARGIN_W-1:0]       margin;
  } ffc_item_t;

endpackage

// File: rtl/ffc_plane_cell.sv
// One plane cell of the rotating plane ring.
module ffc_plane_cell
  import ffc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               shift_i,
  input  logic [PLANE_W-1:0] cfg_data_i,
  input  logic [PLANE_W-1:0] next_i,
  output logic [PLANE_W-1:0] plane_o
);

  logic [PLANE_W-1:0] plane_q;

  // The user must load only while the ring is at rest, so loads never meet a shift; the cell does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (load_i) begin
      plane_q <= cfg_data_i;
    end else if (shift_i) begin
      plane_q <= next_i;
    end
  end

  assign plane_o = plane_q;

endmodule

// File: rtl/ffc_eval.sv
// Four-stage plane evaluation unit: one plane enters per cycle, one pass bit leaves.
module ffc_eval
  import ffc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [PLANE_W-1:0] plane_i,
  input  ffc_item_t          item_i,
  output logic               pass_valid_o,
  output logic               pass_o
);

  logic signed [COORD_W-1:0] nrm [3];
  logic signed [COORD_W-1:0] ofs;
  logic [AXIS_W-1:0]         axes [3];
  logic signed [COORD_W-1:0] bext [3];
  logic signed [COORD_W-1:0] cx, cy, cz;
  logic                      is_aabb;

  // Stage 1: the twelve products.
  logic                      s1_valid_q;
  logic signed [31:0]        s1_px_d, s1_py_d, s1_pz_d;
  logic signed [31:0]        s1_px_q, s1_py_q, s1_pz_q;
  logic signed [COORD_W-1:0] s1_w_q;
  logic signed [31:0]        s1_pj_d [3][3];
  logic signed [31:0]        s1_pj_q [3][3];

  // Stage 2: distance and projected axis magnitudes.
  logic                      s2_valid_q;
  logic signed [33:0]        s2_d_d, s2_d_q;
  logic signed [33:0]        s2_sum [3];
  logic [31:0]               s2_abs_d [3];
  logic [31:0]               s2_abs_q [3];

  // Stage 3: extent products and the simple tests.
  logic                      s3_valid_q;
  logic signed [48:0]        s3_prod_d [3];
  logic signed [48:0]        s3_prod_q [3];
  logic signed [33:0]        s3_d_q;
  logic                      s3_pass_d, s3_pass_q;
  logic signed [35:0]        d_ext, rad_term, marg_term;

  // Stage 4: oriented box total and the final pass bit.
  logic                      s4_valid_q;
  logic                      s4_pass_d, s4_pass_q;
  logic signed [51:0]        total;

  assign nrm[0] = plane_i[63:48];
  assign nrm[1] = plane_i[47:32];
  assign nrm[2] = plane_i[31:16];
  assign ofs    = plane_i[15:0];

  assign axes[0] = item_i.axis_u;
  assign axes[1] = item_i.axis_v;
  assign axes[2] = item_i.axis_w;
  assign bext[0] = item_i.bx;
  assign bext[1] = item_i.by;
  assign bext[2] = item_i.bz;

  // The aligned box test takes the corner furthest along the normal.
  assign is_aabb = (item_i.cmd == CMD_AABB);
  assign cx = (is_aabb && !nrm[0][COORD_W-1]) ? item_i.bx : item_i.ax;
  assign cy = (is_aabb && !nrm[1][COORD_W-1]) ? item_i.by : item_i.ay;
  assign cz = (is_aabb && !nrm[2][COORD_W-1]) ? item_i.bz : item_i.az;

  always_comb begin
    s1_px_d = 32'(nrm[0]) * 32'(cx);
    s1_py_d = 32'(nrm[1]) * 32'(cy);
    s1_pz_d = 32'(nrm[2]) * 32'(cz);
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        s1_pj_d[k][j] = 32'(nrm[j]) * 32'($signed(axes[k][AXIS_W-1-COORD_W*j -: COORD_W]));
      end
    end
  end

  always_comb begin
    s2_d_d = 34'(s1_px_q) + 34'(s1_py_q) + 34'(s1_pz_q) + (34'(s1_w_q) <<< 14);
    for (int k = 0; k < 3; k++) begin
      s2_sum[k]   = 34'(s1_pj_q[k][0]) + 34'(s1_pj_q[k][1]) + 34'(s1_pj_q[k][2]);
      s2_abs_d[k] = s2_sum[k][33] ? 32'(-s2_sum[k]) : 32'(s2_sum[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s3_prod_d[k] = 49'($signed({1'b0, s2_abs_q[k]})) * 49'(bext[k]);
    end
    d_ext     = 36'(s2_d_q);
    rad_term  = $signed({7'b0, item_i.radius, 14'b0});
    marg_term = $signed({7'b0, item_i.margin, 14'b0});
    if (item_i.cmd inside {CMD_POINT, CMD_LIST}) begin
      s3_pass_d = (d_ext > 36'sd0);
    end else if (item_i.cmd == CMD_SPHERE) begin
      s3_pass_d = !(36'(d_ext + rad_term) < 36'sd0);
    end else if (item_i.cmd == CMD_AABB) begin
      s3_pass_d = !(36'(d_ext + marg_term) < 36'sd0);
    end else begin
      s3_pass_d = 1'b0;
    end
  end

  always_comb begin
    total = (52'(s3_d_q) <<< 14) + 52'(s3_prod_q[0]) + 52'(s3_prod_q[1])
          + 52'(s3_prod_q[2]) + $signed({9'b0, item_i.margin, 28'b0});
    s4_pass_d = (item_i.cmd == CMD_OBB) ? !total[51] : s3_pass_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_px_q   <= s1_px_d;
    s1_py_q   <= s1_py_d;
    s1_pz_q   <= s1_pz_d;
    s1_w_q    <= ofs;
    s1_pj_q   <= s1_pj_d;
    s2_d_q    <= s2_d_d;
    s2_abs_q  <= s2_abs_d;
    s3_prod_q <= s3_prod_d;
    s3_d_q    <= s2_d_q;
    s3_pass_q <= s3_pass_d;
    s4_pass_q <= s4_pass_d;
  end

  assign pass_valid_o = s4_valid_q;
  assign pass_o       = s4_pass_q;

endmodule

// File: rtl/frustum_cull_test_unit.sv
// Top level of the six-plane frustum cull test unit.
//
// Each accepted transaction tests one primitive (point, point-list member, sphere,
// aligned box or oriented box, chosen by cmd) against the six frustum planes held in
// configuration. The planes sit in a ring of plane cells; while an item is worked on
// the ring turns once, one step per cycle, and the cell at its head feeds the shared
// four-stage evaluation unit, so one plane is evaluated per cycle. An item goes through
// the issue steps through the ring, then waits while the evaluation unit drains, then
// registers any result it owes and returns to idle, where the next transaction is taken.
// No new item is taken before the last is through; finishing waits only while the
// output register is still held by out_stall_i. Commands five to seven are accepted
// and dropped in the same cycle with no effect. Point-list members gather an
// any-inside flag; only the member marked last produces a result, which clears the
// flag. The user writes configuration through cfg_we_i, cfg_idx_i and cfg_data_i only
// while the unit is idle; the unit does not enforce this. Indexes 0 to 5 are the right,
// left, top, bottom, far and near planes, index 6 is the box margin, others are ignored.
module frustum_cull_test_unit
  import ffc_pkg::*;
#(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  localparam int CfgIdxW    = $clog2(PLANE_COUNT + 1),
  localparam int PlCntW     = $clog2(PLANE_COUNT)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port.
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [PLANE_W-1:0]        cfg_data_i,
  // Input channel.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CMD_W-1:0]          cmd_i,
  input  logic signed [COORD_W-1:0] ax_i,
  input  logic signed [COORD_W-1:0] ay_i,
  input  logic signed [COORD_W-1:0] az_i,
  input  logic signed [COORD_W-1:0] bx_i,
  input  logic signed [COORD_W-1:0] by_i,
  input  logic signed [COORD_W-1:0] bz_i,
  input  logic [MARGIN_W-1:0]       radius_i,
  input  logic [AXIS_W-1:0]         axis_u_i,
  input  logic [AXIS_W-1:0]         axis_v_i,
  input  logic [AXIS_W-1:0]         axis_w_i,
  input  logic                      last_i,
  // Output channel.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      inside_res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [PlCntW-1:0]   issue_cnt_q;
  logic [PlCntW-1:0]   done_cnt_q;
  logic                all_pass_q;
  logic                flag_q;
  logic                out_valid_q;
  logic                out_res_q;
  logic [MARGIN_W-1:0] margin_q;

  logic                in_accept;
  logic                slot_free;
  logic                out_load;
  logic                ring_shift;
  logic                flag_d;
  logic                ev_pass_valid;
  logic                ev_pass;

  ffc_item_t           item_q;
  ffc_item_t           item_cur;

  logic [PLANE_W-1:0]  ring [PLANE_COUNT];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The output register can take a new result if it is empty or is being emptied now.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign ring_shift = (state_q == ST_ISSUE);
  // A finishing item that owes a result loads the output register once it is free.
  assign out_load   = (state_q == ST_FINISH) && slot_free
                      && !(item_q.cmd == CMD_LIST && !item_q.last);

  // Margin is config; the user holds it steady while an item is in flight (unchecked).
  always_comb begin
    item_cur        = item_q;
    item_cur.margin = margin_q;
  end

  // Plane ring: cell i takes its neighbour's plane on every issue cycle, so the head
  // cell presents each plane in turn and the ring is back home after one full turn.
  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    ffc_plane_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (cfg_we_i && (cfg_idx_i == CfgIdxW'(i))),
      .shift_i    (ring_shift),
      .cfg_data_i (cfg_data_i),
      .next_i     (ring[(i + 1) % PLANE_COUNT]),
      .plane_o    (ring[i])
    );
  end

  ffc_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (ring_shift),
    .plane_i      (ring[0]),
    .item_i       (item_cur),
    .pass_valid_o (ev_pass_valid),
    .pass_o       (ev_pass)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_W'(1);
    end else if (cfg_we_i && (cfg_idx_i == CfgIdxW'(PLANE_COUNT))) begin
      margin_q <= cfg_data_i[MARGIN_W-1:0];
    end
  end

  // Item registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.cmd    <= cmd_i;
      item_q.ax     <= ax_i;
      item_q.ay     <= ay_i;
      item_q.az     <= az_i;
      item_q.bx     <= bx_i;
      item_q.by     <= by_i;
      item_q.bz     <= bz_i;
      item_q.radius <= radius_i;
      item_q.axis_u <= axis_u_i;
      item_q.axis_v <= axis_v_i;
      item_q.axis_w <= axis_w_i;
      item_q.last   <= last_i;
      item_q.margin <= '0;
    end
  end

  // The list flag including the member now finishing.
  assign flag_d = flag_q | all_pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_cnt_q <= '0;
      done_cnt_q  <= '0;
      all_pass_q  <= 1'b1;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ev_pass_valid) begin
        all_pass_q <= all_pass_q & ev_pass;
        done_cnt_q <= done_cnt_q + PlCntW'(1);
      end
      case (state_q)
        ST_IDLE: begin
          // Unused commands are taken and dropped; only the item payload registers load them.
          if (in_accept && (cmd_i <= CMD_OBB)) begin
            state_q     <= ST_ISSUE;
            issue_cnt_q <= '0;
            done_cnt_q  <= '0;
            all_pass_q  <= 1'b1;
          end
        end
        ST_ISSUE: begin
          if (issue_cnt_q == PlCntW'(PLANE_COUNT - 1)) begin
            issue_cnt_q <= '0;
            state_q     <= ST_DRAIN;
          end else begin
            issue_cnt_q <= issue_cnt_q + PlCntW'(1);
          end
        end
        ST_DRAIN: begin
          if (ev_pass_valid && (done_cnt_q == PlCntW'(PLANE_COUNT - 1))) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (item_q.cmd == CMD_LIST && !item_q.last) begin
            flag_q  <= flag_d;
            state_q <= ST_IDLE;
          end else if (slot_free) begin
            state_q <= ST_IDLE;
            if (item_q.cmd == CMD_LIST) begin
              out_res_q <= flag_d;
              flag_q    <= 1'b0;
            end else begin
              out_res_q <= all_pass_q;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_res_q;

`include "frustum_cull_test_unit_assert.svh"

  // Plane results arrive only while an item is being worked on.
  `FFC_ASSERT_IMP(a_pass_in_flight, ev_pass_valid, (state_q == ST_ISSUE || state_q == ST_DRAIN))
  // A new result is only ever loaded from the finishing state.
  `FFC_ASSERT_IMP(a_out_from_finish, $rose(out_valid_q), $past(state_q) == ST_FINISH)
  // Reporting the last member of a point list leaves the flag clear.
  `FFC_ASSERT_NXT(a_flag_cleared,
    (state_q == ST_FINISH && slot_free && item_q.cmd == CMD_LIST && item_q.last), !flag_q)

endmodule
